[rtl/dpxru_pkg.sv]
// ----------------------------------------------------------------------------
// dpxru_pkg
// Shared types and constants of the DPX row sample unpacker: register
// indexes, format codes, channel payloads and the queue entry format.
// ----------------------------------------------------------------------------
package dpxru_pkg;

    // Row limit ceiling and counter width
    localparam int MAX_ROW_SAMPLES = 32768;
    localparam int CNT_W           = 16;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_IN_MSB     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LITTLE_ENDIAN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DATUMS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH     = 3'd4;

    // Sample format codes
    localparam logic [2:0] FMT_8  = 3'd0;
    localparam logic [2:0] FMT_10 = 3'd1;
    localparam logic [2:0] FMT_12 = 3'd2;
    localparam logic [2:0] FMT_16 = 3'd3;
    localparam logic [2:0] FMT_32 = 3'd4;

    typedef struct packed {
        logic [2:0]       sample_format;
        logic             pad_in_msb;
        logic             little_endian;
        logic             reverse_datums;
        logic [CNT_W-1:0] row_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       row_end;
    } t_in;

    typedef struct packed {
        logic [31:0] sample;
        logic        run_last;
        logic        row_last;
    } t_out;

    // One completed word: up to three samples
    typedef struct packed {
        logic [31:0] sample0;
        logic [9:0]  sample1;
        logic [9:0]  sample2;
        logic [1:0]  count;
        logic        row_last;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

endpackage

[rtl/dpxru_front.sv]
// ----------------------------------------------------------------------------
// dpxru_front
// Gathers scanline bytes into words, splits each completed word into its
// samples, clips them to the row limit and pushes each word inside the row.
// ----------------------------------------------------------------------------
module dpxru_front
    import dpxru_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_in_valid,
    input  t_in    i_in_data,
    output logic   o_in_ready,
    input  logic   i_full,
    output logic   o_push,
    output t_entry o_entry
);

    localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'(MAX_ROW_SAMPLES);

    logic [23:0]      r_gather, n_gather;
    logic [1:0]       r_pos, n_pos;
    logic [CNT_W-1:0] r_done, n_done;

    logic             accept;
    logic             fmt_ok;
    logic             active;
    logic             word_done;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] remain;
    logic [CNT_W-1:0] done_sum;
    logic [7:0]       b0, b1, b2, b3;
    logic [31:0]      word;
    logic [9:0]       d_lo, d_mid, d_hi;
    logic [1:0]       cnt;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;

    // Row limit and activity
    assign limit  = (i_cfg.row_length > LIMIT_MAX) ? LIMIT_MAX : i_cfg.row_length;
    assign fmt_ok = (i_cfg.sample_format <= FMT_32);
    assign active = fmt_ok && (r_done < limit);

    // Word completes on the last byte of its size
    always_comb begin
        case (i_cfg.sample_format)
            FMT_8:          word_done = 1'b1;
            FMT_12, FMT_16: word_done = (r_pos >= 2'd1);
            default:        word_done = (r_pos == 2'd3);
        endcase
    end

    // Assemble word, newest byte in b0
    assign b0 = i_in_data.data_byte;
    assign b1 = r_gather[7:0];
    assign b2 = r_gather[15:8];
    assign b3 = r_gather[23:16];

    always_comb begin
        case (i_cfg.sample_format)
            FMT_8:          word = {24'd0, b0};
            FMT_12, FMT_16: word = i_cfg.little_endian ? {16'd0, b0, b1} : {16'd0, b1, b0};
            default:        word = i_cfg.little_endian ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
        endcase
    end

    // Three 10-bit datums, padding in LSB or MSB
    assign d_lo  = i_cfg.pad_in_msb ? word[9:0]   : word[11:2];
    assign d_mid = i_cfg.pad_in_msb ? word[19:10] : word[21:12];
    assign d_hi  = i_cfg.pad_in_msb ? word[29:20] : word[31:22];

    // Clip sample count to what the row still needs
    assign remain = limit - r_done;
    always_comb begin
        if (i_cfg.sample_format != FMT_10) begin
            cnt = 2'd1;
        end else if (remain >= CNT_W'(3)) begin
            cnt = 2'd3;
        end else begin
            cnt = remain[1:0];
        end
    end
    assign done_sum = r_done + CNT_W'(cnt);

    // Build the queue entry
    always_comb begin
        o_entry.sample1  = d_mid;
        o_entry.sample2  = i_cfg.reverse_datums ? d_lo : d_hi;
        o_entry.count    = cnt;
        o_entry.row_last = (done_sum == limit);
        case (i_cfg.sample_format)
            FMT_10:  o_entry.sample0 = {22'd0, (i_cfg.reverse_datums ? d_hi : d_lo)};
            FMT_12:  o_entry.sample0 = i_cfg.pad_in_msb ? {20'd0, word[11:0]}
                                                        : {20'd0, word[15:4]};
            default: o_entry.sample0 = word;
        endcase
    end

    assign o_push = accept && active && word_done;

    // Advance gather state; row end drops everything
    always_comb begin
        n_gather = r_gather;
        n_pos    = r_pos;
        n_done   = r_done;
        if (accept) begin
            if (active) begin
                if (word_done) begin
                    n_pos  = 2'd0;
                    n_done = done_sum;
                end else begin
                    n_pos = r_pos + 2'd1;
                end
                n_gather = {r_gather[15:0], i_in_data.data_byte};
            end
            if (i_in_data.row_end) begin
                n_gather = 24'd0;
                n_pos    = 2'd0;
                n_done   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gather <= 24'd0;
            r_pos    <= 2'd0;
            r_done   <= '0;
        end else begin
            r_gather <= n_gather;
            r_pos    <= n_pos;
            r_done   <= n_done;
        end
    end

endmodule

[rtl/dpxru_fifo.sv]
// ----------------------------------------------------------------------------
// dpxru_fifo
// Short word queue between front and back; one push and one pop per cycle.
// ----------------------------------------------------------------------------
module dpxru_fifo
    import dpxru_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_entry     i_entry,
    input  logic       i_pop,
    output t_entry     o_head,
    output t_fifo_stat o_stat
);

    t_entry               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_head       = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    // Wrap pointers at the queue depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + FIFO_AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + FIFO_AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + FIFO_CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - FIFO_CW'(1);
        end
    end

    // Store entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[rtl/dpxru_back.sv]
// ----------------------------------------------------------------------------
// dpxru_back
// Walks the samples of the queue head into the output register, one per
// cycle while it is free; flags the last sample of each word and of the row.
// ----------------------------------------------------------------------------
module dpxru_back
    import dpxru_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_head,
    input  t_fifo_stat i_stat,
    output logic       o_pop,
    output logic       o_out_valid,
    output t_out       o_out_data,
    input  logic       i_out_ready
);

    logic [1:0]  r_sub, n_sub;
    logic        r_out_valid, n_out_valid;
    t_out        r_out, n_out;
    logic        out_free;
    logic        take;
    logic        is_last;
    logic [31:0] sel_sample;

    assign out_free = !r_out_valid || i_out_ready;
    assign take     = out_free && !i_stat.empty;
    assign is_last  = (2'(r_sub + 2'd1) == i_head.count);
    assign o_pop    = take && is_last;

    // Pick the current sample of the head word
    always_comb begin
        case (r_sub)
            2'd0:    sel_sample = i_head.sample0;
            2'd1:    sel_sample = {22'd0, i_head.sample1};
            default: sel_sample = {22'd0, i_head.sample2};
        endcase
    end

    // Load the output register when it is free
    always_comb begin
        n_sub       = r_sub;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (take) begin
            n_out_valid     = 1'b1;
            n_out.sample    = sel_sample;
            n_out.run_last  = is_last;
            n_out.row_last  = is_last && i_head.row_last;
            n_sub           = is_last ? 2'd0 : r_sub + 2'd1;
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_sub       <= n_sub;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/dpx_row_sample_unpacker_unit.sv]
// ----------------------------------------------------------------------------
// dpx_row_sample_unpacker_unit
// DPX scanline byte stream in, unpacked samples out.
// ----------------------------------------------------------------------------
// The unit takes one scanline byte per cycle unless its queue is full and
// emits at most one sample per cycle. Bytes are gathered into words (1, 2 or
// 4 bytes by format); each completed word goes into a four-entry queue, and
// the back end drains up to three samples per word, one per cycle while the
// output is free, through a registered output. Input stalls only when the
// queue is full, which in steady state happens only while the output side
// is stalled. Samples beyond the row count are dropped; row_end restarts the
// row. Write configuration only while idle.
module dpx_row_sample_unpacker_unit
    import dpxru_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    input  logic                  i_in_valid,
    input  t_in                   i_in_data,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output t_out                  o_out_data,
    input  logic                  i_out_ready
);

    t_cfg       r_cfg, n_cfg;
    logic       push;
    logic       pop;
    t_entry     push_entry;
    t_entry     head;
    t_fifo_stat fifo_stat;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SAMPLE_FORMAT:  n_cfg.sample_format  = i_cfg_data[2:0];
                REG_PAD_IN_MSB:     n_cfg.pad_in_msb     = i_cfg_data[0];
                REG_LITTLE_ENDIAN:  n_cfg.little_endian  = i_cfg_data[0];
                REG_REVERSE_DATUMS: n_cfg.reverse_datums = i_cfg_data[0];
                REG_ROW_LENGTH:     n_cfg.row_length     = i_cfg_data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_format  <= FMT_8;
            r_cfg.pad_in_msb     <= 1'b0;
            r_cfg.little_endian  <= 1'b0;
            r_cfg.reverse_datums <= 1'b0;
            r_cfg.row_length     <= CNT_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    dpxru_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_full     (fifo_stat.full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    dpxru_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (fifo_stat)
    );

    dpxru_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_stat      (fifo_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

`ifndef SYNTHESIS
    // Queue cannot be empty and full at once
    a_fifo_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_stat.empty && fifo_stat.full))
        else $error("queue reports empty and full together");

    // Row end sample always closes its word
    a_row_last_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.row_last) |-> o_out_data.run_last)
        else $error("row_last without run_last");

    // Output drops after reset
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // Never push into a full queue
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !fifo_stat.full)
        else $error("push while queue full");
`endif

endmodule
